FILE: rtl/azz_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// azz_pkg
// Shared widths, types and constant tables for the Cartesian to azimuth and
// zenith converter.
// -----------------------------------------------------------------------------
package azz_pkg;

  localparam int COORD_BITS      = 24;
  localparam int ANGLE_FRAC_BITS = 10;
  localparam int CORDIC_STAGES   = 20;
  localparam int STAGE_N         = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int GUARD_BITS      = 16;
  localparam int ANG_Q           = 24;
  localparam int DW              = COORD_BITS + GUARD_BITS + 4;
  localparam int AW              = ANG_Q + 11;
  localparam int SHIFT_W         = 5;
  localparam int GAIN_W          = 34;
  localparam int MUL_SPLIT       = 20;
  localparam int MUL_SHIFT       = 12;
  localparam int AZ_W            = 19;
  localparam int ZEN_W           = 18;
  localparam int RANGE_W         = 24;
  localparam int IN_DATA_W       = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W    = AZ_W + ZEN_W + RANGE_W;
  localparam int OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic signed [DW-1:0] vec_t;
  typedef logic signed [AW-1:0] ang_t;

  typedef struct packed {
    vec_t z;
    ang_t a1;
    ang_t a2;
    logic xy_zero;
    logic degenerate;
  } side_t;

  function automatic logic [GAIN_W-1:0] inv_gain();
    logic [63:0] q;
    q = 64'd2608131496;
    if (2 * STAGE_N < 40) begin
      q = q + (((q * 64'd2) / 64'd3) >> (2 * STAGE_N));
    end
    return q[GAIN_W-1:0];
  endfunction

  localparam logic [GAIN_W-1:0] INV_GAIN = inv_gain();

  // atan(2^-i) in degrees with ANG_Q fraction bits, rounded.
  function automatic ang_t atan_step(input logic [SHIFT_W-1:0] i);
    ang_t r;
    unique case (i)
      5'd0:  r = ang_t'(64'd754974720);
      5'd1:  r = ang_t'(64'd445687602);
      5'd2:  r = ang_t'(64'd235489088);
      5'd3:  r = ang_t'(64'd119537938);
      5'd4:  r = ang_t'(64'd60000934);
      5'd5:  r = ang_t'(64'd30029717);
      5'd6:  r = ang_t'(64'd15018523);
      5'd7:  r = ang_t'(64'd7509720);
      5'd8:  r = ang_t'(64'd3754917);
      5'd9:  r = ang_t'(64'd1877466);
      5'd10: r = ang_t'(64'd938734);
      5'd11: r = ang_t'(64'd469367);
      5'd12: r = ang_t'(64'd234684);
      5'd13: r = ang_t'(64'd117342);
      5'd14: r = ang_t'(64'd58671);
      5'd15: r = ang_t'(64'd29335);
      5'd16: r = ang_t'(64'd14668);
      5'd17: r = ang_t'(64'd7334);
      5'd18: r = ang_t'(64'd3667);
      5'd19: r = ang_t'(64'd1833);
      5'd20: r = ang_t'(64'd917);
      5'd21: r = ang_t'(64'd458);
      5'd22: r = ang_t'(64'd229);
      5'd23: r = ang_t'(64'd115);
      5'd24: r = ang_t'(64'd57);
      5'd25: r = ang_t'(64'd29);
      5'd26: r = ang_t'(64'd14);
      5'd27: r = ang_t'(64'd7);
      5'd28: r = ang_t'(64'd4);
      5'd29: r = ang_t'(64'd2);
      5'd30: r = ang_t'(64'd1);
      5'd31: r = ang_t'(64'd0);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/azz_cordic_stage.sv
`default_nettype none
// -----------------------------------------------------------------------------
// azz_cordic_stage
// One registered CORDIC vectoring micro-rotation with side data carried along.
// -----------------------------------------------------------------------------
module azz_cordic_stage (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic [azz_pkg::SHIFT_W-1:0]  shift,
  input  wire azz_pkg::ang_t                atan_val,
  input  wire logic                         in_valid,
  input  wire azz_pkg::vec_t                in_x,
  input  wire azz_pkg::vec_t                in_y,
  input  wire azz_pkg::ang_t                in_a,
  input  wire azz_pkg::side_t               in_side,
  output      logic                         out_valid,
  output      azz_pkg::vec_t                out_x,
  output      azz_pkg::vec_t                out_y,
  output      azz_pkg::ang_t                out_a,
  output      azz_pkg::side_t               out_side
);
  import azz_pkg::*;

  vec_t dx;
  vec_t dy;

  assign dx = in_y >>> shift;
  assign dy = in_x >>> shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      if (in_y > 0) begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_a <= in_a + atan_val;
      end else begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_a <= in_a - atan_val;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/azz_gain.sv
`default_nettype none
// -----------------------------------------------------------------------------
// azz_gain
// Two-stage removal of the CORDIC gain: split partial products, then sum.
// -----------------------------------------------------------------------------
module azz_gain (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire azz_pkg::vec_t   in_vec,
  input  wire azz_pkg::side_t  in_side,
  output      logic            out_valid,
  output      azz_pkg::vec_t   out_mag,
  output      azz_pkg::side_t  out_side
);
  import azz_pkg::*;

  localparam int MAG_W = DW - 1;
  localparam int HI_W  = MAG_W - MUL_SPLIT + GAIN_W;
  localparam int LO_W  = MUL_SPLIT + GAIN_W;

  logic [MAG_W-1:0] mag;
  logic [HI_W-1:0]  hi_prod;
  logic [LO_W-1:0]  lo_prod;
  logic [HI_W:0]    sum;
  logic [HI_W-1:0]  hi_p;
  logic [GAIN_W-1:0] lo_p;
  logic             mid_valid;
  side_t            mid_side;

  assign mag     = in_vec[DW-1] ? '0 : in_vec[MAG_W-1:0];
  assign hi_prod = HI_W'(mag[MAG_W-1:MUL_SPLIT]) * HI_W'(INV_GAIN);
  assign lo_prod = LO_W'(mag[MUL_SPLIT-1:0]) * LO_W'(INV_GAIN);
  assign sum     = (HI_W+1)'(hi_p) + (HI_W+1)'(lo_p);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_p     <= hi_prod;
      lo_p     <= lo_prod[LO_W-1:MUL_SPLIT];
      mid_side <= in_side;
      out_mag  <= {1'b0, sum[DW+MUL_SHIFT-2:MUL_SHIFT]};
      out_side <= mid_side;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cartesian_to_azimuth_zenith_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// cartesian_to_azimuth_zenith_core
// Converts a signed Cartesian vector to azimuth, zenith angle and range with
// two CORDIC vectoring passes, each followed by gain removal.
//
//   Channel  | Direction | tdata (low bit up)            | tuser
//   s_axis   | in        | x_pos, y_pos, z_pos           | -
//   m_axis   | out       | azimuth, zenith, range_len    | degenerate
//
// One vector is taken every cycle while the skid register is empty. The path
// runs through the input register, two unrolled CORDIC passes, two gain
// multipliers, a finishing register and the output register.
// Reset clears the valid bits only. A stall at the output fills a skid
// register; the pipeline then holds until the skid drains.
// -----------------------------------------------------------------------------
module cartesian_to_azimuth_zenith_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // x_pos, y_pos, z_pos
  input  wire logic [azz_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // azimuth, zenith, range_len, zero fill
  output      logic [azz_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // degenerate
  output      logic                             m_axis_tuser
);
  import azz_pkg::*;

  localparam int   S_RND     = ANG_Q - ANGLE_FRAC_BITS;
  localparam ang_t HALF_TURN = ang_t'(64'd180 << ANG_Q);
  localparam ang_t ANG_RND   = ang_t'(64'd1 << (S_RND - 1));
  localparam ang_t QUARTER   = ang_t'(64'd90 << ANGLE_FRAC_BITS);
  localparam ang_t HALF_OUT  = ang_t'(64'd180 << ANGLE_FRAC_BITS);
  localparam ang_t FULL_OUT  = ang_t'(64'd360 << ANGLE_FRAC_BITS);
  localparam logic [DW:0] RANGE_RND = (DW+1)'(64'd1 << (GUARD_BITS - 1));
  localparam logic [DW:0] RANGE_MAX = (DW+1)'((64'd1 << RANGE_W) - 64'd1);

  logic en;
  logic push;

  logic signed [COORD_BITS-1:0] x_in;
  logic signed [COORD_BITS-1:0] y_in;
  logic signed [COORD_BITS-1:0] z_in;
  vec_t x_sc;
  vec_t y_sc;
  vec_t z_sc;
  ang_t a_init;
  side_t side_in;

  logic  p1_v [0:STAGE_N];
  vec_t  p1_x [0:STAGE_N];
  vec_t  p1_y [0:STAGE_N];
  ang_t  p1_a [0:STAGE_N];
  side_t p1_s [0:STAGE_N];

  logic  p2_v [0:STAGE_N];
  vec_t  p2_x [0:STAGE_N];
  vec_t  p2_y [0:STAGE_N];
  ang_t  p2_a [0:STAGE_N];
  side_t p2_s [0:STAGE_N];

  side_t g1_in_side;
  logic  g1_v;
  vec_t  g1_mag;
  side_t g1_s;
  side_t g2_in_side;
  logic  g2_v;
  vec_t  g2_mag;
  side_t g2_s;

  logic [AZ_W-1:0]    az_next;
  logic [ZEN_W-1:0]   zen_next;
  logic [RANGE_W-1:0] rng_next;

  logic                    pv;
  logic [OUT_FIELDS_W:0]   pd;
  logic                    ov;
  logic [OUT_FIELDS_W:0]   od;
  logic                    sv;
  logic [OUT_FIELDS_W:0]   sd;

  assign en            = !sv;
  assign s_axis_tready = !sv;
  assign push          = pv && en;

  assign x_in   = s_axis_tdata[COORD_BITS-1:0];
  assign y_in   = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign z_in   = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign x_sc   = vec_t'(x_in) <<< GUARD_BITS;
  assign y_sc   = vec_t'(y_in) <<< GUARD_BITS;
  assign z_sc   = vec_t'(z_in) <<< GUARD_BITS;
  assign a_init = x_in[COORD_BITS-1] ? (y_in[COORD_BITS-1] ? -HALF_TURN : HALF_TURN) : '0;

  always_comb begin
    side_in.z          = z_sc;
    side_in.a1         = '0;
    side_in.a2         = '0;
    side_in.xy_zero    = (x_in == '0) && (y_in == '0);
    side_in.degenerate = (x_in == '0) && (y_in == '0) && (z_in == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v[0] <= 1'b0;
    end else if (en) begin
      p1_v[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x[0] <= x_in[COORD_BITS-1] ? -x_sc : x_sc;
      p1_y[0] <= x_in[COORD_BITS-1] ? -y_sc : y_sc;
      p1_a[0] <= a_init;
      p1_s[0] <= side_in;
    end
  end

  for (genvar k = 0; k < STAGE_N; k++) begin : g_pass1
    azz_cordic_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .shift     (SHIFT_W'(k)),
      .atan_val  (atan_step(SHIFT_W'(k))),
      .in_valid  (p1_v[k]),
      .in_x      (p1_x[k]),
      .in_y      (p1_y[k]),
      .in_a      (p1_a[k]),
      .in_side   (p1_s[k]),
      .out_valid (p1_v[k+1]),
      .out_x     (p1_x[k+1]),
      .out_y     (p1_y[k+1]),
      .out_a     (p1_a[k+1]),
      .out_side  (p1_s[k+1])
    );
  end

  always_comb begin
    g1_in_side    = p1_s[STAGE_N];
    g1_in_side.a1 = p1_s[STAGE_N].xy_zero ? '0 : p1_a[STAGE_N];
  end

  azz_gain u_gain1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p1_v[STAGE_N]),
    .in_vec    (p1_x[STAGE_N]),
    .in_side   (g1_in_side),
    .out_valid (g1_v),
    .out_mag   (g1_mag),
    .out_side  (g1_s)
  );

  assign p2_v[0] = g1_v;
  assign p2_x[0] = g1_s.xy_zero ? '0 : g1_mag;
  assign p2_y[0] = g1_s.z;
  assign p2_a[0] = '0;
  assign p2_s[0] = g1_s;

  for (genvar k = 0; k < STAGE_N; k++) begin : g_pass2
    azz_cordic_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .shift     (SHIFT_W'(k)),
      .atan_val  (atan_step(SHIFT_W'(k))),
      .in_valid  (p2_v[k]),
      .in_x      (p2_x[k]),
      .in_y      (p2_y[k]),
      .in_a      (p2_a[k]),
      .in_side   (p2_s[k]),
      .out_valid (p2_v[k+1]),
      .out_x     (p2_x[k+1]),
      .out_y     (p2_y[k+1]),
      .out_a     (p2_a[k+1]),
      .out_side  (p2_s[k+1])
    );
  end

  always_comb begin
    g2_in_side    = p2_s[STAGE_N];
    g2_in_side.a2 = p2_a[STAGE_N];
  end

  azz_gain u_gain2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p2_v[STAGE_N]),
    .in_vec    (p2_x[STAGE_N]),
    .in_side   (g2_in_side),
    .out_valid (g2_v),
    .out_mag   (g2_mag),
    .out_side  (g2_s)
  );

  always_comb begin
    logic [DW:0] rnd;
    logic [DW:0] rr;
    ang_t        ao1;
    ang_t        ao2;
    ang_t        v;
    ang_t        zen;
    rnd = (DW+1)'(g2_mag[DW-2:0]) + RANGE_RND;
    rr  = rnd >> GUARD_BITS;
    if (rr > RANGE_MAX) begin
      rr = RANGE_MAX;
    end
    ao1 = (g2_s.a1 + ANG_RND) >>> S_RND;
    ao2 = (g2_s.a2 + ANG_RND) >>> S_RND;
    v   = -(ao1 + QUARTER);
    if (v < 0) begin
      v = v + FULL_OUT;
    end
    if (v < 0) begin
      v = v + FULL_OUT;
    end
    if (v >= FULL_OUT) begin
      v = v - FULL_OUT;
    end
    zen = QUARTER - ao2;
    if (zen < 0) begin
      zen = '0;
    end
    if (zen > HALF_OUT) begin
      zen = HALF_OUT;
    end
    if (g2_s.degenerate) begin
      az_next  = '0;
      zen_next = '0;
      rng_next = '0;
    end else begin
      az_next  = AZ_W'(v);
      zen_next = ZEN_W'(zen);
      rng_next = rr[RANGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= g2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd <= {g2_s.degenerate, rng_next, zen_next, az_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || m_axis_tready) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= push;
      end
    end else if (push) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || m_axis_tready) begin
      od <= sv ? sd : pd;
    end else if (push) begin
      sd <= pd;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = OUT_DATA_W'(od[OUT_FIELDS_W-1:0]);
  assign m_axis_tuser  = od[OUT_FIELDS_W];

endmodule
`default_nettype wire

FILE: rtl/azz_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// azz_checker
// Port-level checks on the converter's output channel and input ready, bound to the top level.
// -----------------------------------------------------------------------------
module azz_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [azz_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tuser
);
  import azz_pkg::*;

  localparam logic [AZ_W-1:0]  AZ_LIMIT  = AZ_W'(360 << ANGLE_FRAC_BITS);
  localparam logic [ZEN_W-1:0] ZEN_LIMIT = ZEN_W'(180 << ANGLE_FRAC_BITS);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transfer dropped while stalled");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result carries nonzero fields");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[AZ_W-1:0] < AZ_LIMIT) &&
                      (m_axis_tdata[AZ_W+ZEN_W-1:AZ_W] <= ZEN_LIMIT))
    else $error("angle outside its range");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

endmodule

bind cartesian_to_azimuth_zenith_core azz_checker u_azz_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Regression for the Cartesian to azimuth and zenith converter. Directed and
// random vectors stream in with random gaps on both sides, including one long
// output stall. A scoreboard class predicts range, zenith and azimuth with its
// own CORDIC arithmetic and compares every output transfer in order.
// -----------------------------------------------------------------------------
module tb_top;
  import azz_pkg::*;

  typedef struct packed {
    logic [18:0] azimuth;
    logic [17:0] zenith;
    logic [23:0] range_len;
    logic        degenerate;
  } polar_t;

  class polar_scoreboard;
    polar_t pending[$];
    int errors;
    longint atan_tab[32];

    function new();
      atan_tab = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                   15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
                   117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
                   115, 57, 29, 14, 7, 4, 2, 1, 0};
      errors = 0;
    endfunction

    function longint asr(longint v, int s);
      return (v >= 0) ? (v >>> s) : ~((~v) >>> s);
    endfunction

    function void rotate_to_axis(inout longint px, inout longint py, inout longint pa);
      longint dx, dy;
      for (int i = 0; i < STAGE_N; i++) begin
        dx = asr(py, i);
        dy = asr(px, i);
        if (py > 0) begin
          px += dx; py -= dy; pa += atan_tab[i];
        end else begin
          px -= dx; py += dy; pa -= atan_tab[i];
        end
      end
    endfunction

    function longint gain_fix(longint a);
      longint unsigned q, au;
      q = 64'd2608131496;
      if (2 * STAGE_N < 40) q += ((q * 2) / 3) >> (2 * STAGE_N);
      au = a;
      return ((au >> 20) * q + (((au & 64'hFFFFF) * q) >> 20)) >> 12;
    endfunction

    function longint round_angle(longint a);
      return asr(a + (64'sd1 <<< (ANG_Q - ANGLE_FRAC_BITS - 1)), ANG_Q - ANGLE_FRAC_BITS);
    endfunction

    function void note_vector(logic signed [23:0] xi, logic signed [23:0] yi,
                              logic signed [23:0] zi);
      longint x, y, z, a1, a2, h, az, zen, r;
      polar_t p;
      x = xi; y = yi; z = zi; a1 = 0; a2 = 0; h = 0;
      if (x == 0 && y == 0 && z == 0) begin
        p = '0;
        p.degenerate = 1'b1;
        pending.push_back(p);
        return;
      end
      x = x <<< GUARD_BITS;
      y = y <<< GUARD_BITS;
      z = z <<< GUARD_BITS;
      if (x != 0 || y != 0) begin
        if (x < 0) begin
          a1 = (y >= 0 ? 180 : -180) * (64'sd1 <<< ANG_Q);
          x = -x;
          y = -y;
        end
        rotate_to_axis(x, y, a1);
        h = gain_fix(x < 0 ? 0 : x);
      end
      rotate_to_axis(h, z, a2);
      r = gain_fix(h < 0 ? 0 : h);
      r = (r + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
      if (r > 64'hFFFFFF) r = 64'hFFFFFF;
      az = -(round_angle(a1) + 90 * 1024);
      az = az % (360 * 1024);
      if (az < 0) az += 360 * 1024;
      zen = 90 * 1024 - round_angle(a2);
      if (zen < 0) zen = 0;
      if (zen > 180 * 1024) zen = 180 * 1024;
      p.azimuth = az[18:0];
      p.zenith = zen[17:0];
      p.range_len = r[23:0];
      p.degenerate = 1'b0;
      pending.push_back(p);
    endfunction

    function void check_result(polar_t got);
      polar_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected output transfer: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"Mismatch: expected az=%0d zen=%0d range=%0d deg=%0b,",
                    " got az=%0d zen=%0d range=%0d deg=%0b"},
                   want.azimuth, want.zenith, want.range_len, want.degenerate,
                   got.azimuth, got.zenith, got.range_len, got.degenerate);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  polar_scoreboard sb = new();
  bit hold_off = 0;
  int idle_cycles = 0;
  int accepted_in = 0;

  always #2 clk = ~clk;

  cartesian_to_azimuth_zenith_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'sd0;
      1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      2: return 24'($signed($urandom_range(0, 40)) - 20);
      3: return 24'($signed($urandom_range(0, 4000)) - 2000);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic send_vector(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    int g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_vector(x, y, z);
    accepted_in++;
  endtask

  // Output side: random ready, with one long stall while input keeps coming.
  always @(posedge clk) begin
    if (rst || hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(polar_t'({m_axis_tdata[18:0], m_axis_tdata[36:19],
                                m_axis_tdata[60:37], m_axis_tuser}));
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("cartesian_to_azimuth_zenith_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    while (accepted_in < 300) @(posedge clk);
    hold_off = 1'b1;
    repeat (150) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    logic [23:0] mx, mn;
    int tail;
    mx = 24'h7FFFFF;
    mn = 24'h800000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_vector(24'd0, 24'd0, 24'd0);
    send_vector(24'd0, 24'd0, 24'd5);
    send_vector(24'd0, 24'd0, -24'sd5);
    send_vector(mx, mx, mx);
    send_vector(mn, mn, mn);
    send_vector(mx, 24'd0, 24'd0);
    send_vector(mn, 24'd0, 24'd0);
    send_vector(24'd0, mx, 24'd0);
    send_vector(24'd0, mn, 24'd0);
    send_vector(-24'sd3, 24'd0, 24'd0);
    send_vector(-24'sd3, 24'd1, 24'd0);
    send_vector(-24'sd3, -24'sd1, 24'd0);
    send_vector(24'd1, 24'd1, 24'd1);
    send_vector(mx, mn, 24'd0);
    send_vector(mn, mx, mx);
    send_vector(24'd0, 24'd0, mn);
    send_vector(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_vector(24'h555555, 24'hAAAAAA, 24'h555555);
    send_vector(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    for (int i = 0; i < 1300; i++) send_vector(rand_coord(), rand_coord(), rand_coord());
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 100) begin
      @(posedge clk);
      tail++;
    end
    if (sb.errors == 0) begin
      $display("cartesian_to_azimuth_zenith_core regression: pass");
    end else begin
      $display("cartesian_to_azimuth_zenith_core regression: fail");
    end
    $finish;
  end
endmodule
